// ===== sv/lss_pkg.sv =====
// shared types, constants and the sharpen arithmetic for the laplacian sharpen stream
`default_nettype none
package lss_pkg;

	localparam int MAX_ROW_PIXELS = 1024;
	localparam int COL_W = $clog2(MAX_ROW_PIXELS);
	localparam int WIDTH_W = 11;
	localparam int HEIGHT_W = 12;
	localparam int ROW_W = HEIGHT_W;
	localparam int EXT_W = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_WIDTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_HEIGHT = CFG_IDX_W'(1);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	localparam int MAX_RESULTS = 4;
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);
	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [11:0] CTR_GAIN = 12'sd5;
	localparam logic signed [11:0] ACC_MAX = 12'sd255;
	localparam logic signed [11:0] ACC_MIN = 12'sd0;
	localparam logic [7:0] CH_MAX = 8'd255;
	localparam logic [7:0] CH_MIN = 8'd0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       run_last;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic c_ge1;
		logic c_ge2;
		logic r_ge1;
		logic r_ge2;
		logic last_col;
		logic last_row;
	} pos_flags_t;

	function automatic logic [7:0] lss_chan(input logic [7:0] ctr, input logic [7:0] up,
			input logic [7:0] dn, input logic [7:0] lf, input logic [7:0] rt);
		logic signed [11:0] acc;
		acc = CTR_GAIN * signed'({4'b0000, ctr}) - signed'({4'b0000, up})
			- signed'({4'b0000, dn}) - signed'({4'b0000, lf}) - signed'({4'b0000, rt});
		if (acc < ACC_MIN) begin
			return CH_MIN;
		end else if (acc > ACC_MAX) begin
			return CH_MAX;
		end else begin
			return acc[7:0];
		end
	endfunction

	function automatic pix_t lss_sharpen(input pix_t ctr, input pix_t up, input pix_t dn,
			input pix_t lf, input pix_t rt);
		pix_t res;
		res.red = lss_chan(ctr.red, up.red, dn.red, lf.red, rt.red);
		res.green = lss_chan(ctr.green, up.green, dn.green, lf.green, rt.green);
		res.blue = lss_chan(ctr.blue, up.blue, dn.blue, lf.blue, rt.blue);
		return res;
	endfunction

endpackage
`default_nettype wire

// ===== sv/lss_line_buf.sv =====
// two row stores: the older and the newer previous row, each with a registered read
`default_nettype none
module lss_line_buf (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [lss_pkg::COL_W-1:0] rd_addr,
	output lss_pkg::pix_t                 older_rdata,
	output lss_pkg::pix_t                 newer_rdata,
	input  wire logic                     wr_en,
	input  wire logic [lss_pkg::COL_W-1:0] wr_addr,
	input  wire lss_pkg::pix_t            older_wdata,
	input  wire lss_pkg::pix_t            newer_wdata
);
	import lss_pkg::*;

	pix_t older_mem [MAX_ROW_PIXELS];
	pix_t newer_mem [MAX_ROW_PIXELS];
	pix_t older_rd_q;
	pix_t newer_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= older_wdata;
		end
		if (rd_en) begin
			older_rd_q <= older_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			newer_mem[wr_addr] <= newer_wdata;
		end
		if (rd_en) begin
			newer_rd_q <= newer_mem[rd_addr];
		end
	end

	assign older_rdata = older_rd_q;
	assign newer_rdata = newer_rd_q;

endmodule
`default_nettype wire

// ===== sv/lss_out_queue.sv =====
// result queue: takes up to four results a cycle, hands out one a cycle while out_ready is high
`default_nettype none
module lss_out_queue (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lss_pkg::out_item_t               cand [lss_pkg::MAX_RESULTS],
	input  wire logic [lss_pkg::MAX_RESULTS-1:0]  cand_en,
	output logic [lss_pkg::QCNT_W-1:0]            count,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output lss_pkg::out_item_t                    out_data
);
	import lss_pkg::*;

	out_item_t q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] slot_addr [MAX_RESULTS];
	logic [NRES_W-1:0] push_n;
	logic pop;

	// enabled candidates are packed in order behind the write pointer
	always_comb begin
		logic [NRES_W-1:0] off;
		off = '0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			slot_addr[k] = QPTR_W'(wr_ptr_q + QPTR_W'(off));
			off = off + NRES_W'(cand_en[k]);
		end
		push_n = off;
	end

	assign pop = out_valid && out_ready;

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RESULTS; k++) begin
			if (cand_en[k]) begin
				q_mem[slot_addr[k]] <= cand[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(push_n));
			rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(pop));
			count_q <= QCNT_W'(count_q + QCNT_W'(push_n) - QCNT_W'(pop));
		end
	end

	assign count = count_q;
	assign out_valid = (count_q != '0);
	assign out_data = q_mem[rd_ptr_q];

endmodule
`default_nettype wire

// ===== sv/laplacian_sharpen_3x3_stream.sv =====
// top level: position counters, read-modify-write of the row stores, window and result build
// Streaming 5-point sharpen (5*centre minus the four direct neighbours, clamped to 0..255,
// edge neighbours replaced by the centre) over a region of region_width x region_height
// pixels in raster order. A pixel request is accepted every cycle while the 8-entry result
// queue has room for the results still in flight; rows other than the last give one result
// per pixel, so they stream at one pixel per cycle. On the last row each pixel gives two
// results and the row end four, so there the output port, draining one result per cycle
// while out_ready is high, sets the pace. Each pixel passes through the registered row store
// read; its results enter the queue at the end of that stage and are offered at the output
// from the next cycle on. Results of row y come out while row y+1 arrives, one pixel behind.
// Any register write, also to an unused index, restarts the frame; the row stores need no
// clearing after reset.
`default_nettype none
module laplacian_sharpen_3x3_stream (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire lss_pkg::in_item_t            in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output lss_pkg::out_item_t                out_data,
	input  wire logic                         cfg_we,
	input  wire logic [lss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lss_pkg::*;

	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic in_accept;
	logic [EXT_W-1:0] width_ext;
	logic [EXT_W-1:0] width_eff;
	logic [COL_W-1:0] col_last;
	logic [ROW_W-1:0] row_last;
	pos_flags_t flags0;
	logic [NRES_W-1:0] n0;
	logic [QCNT_W-1:0] q_count;
	logic [QCNT_W+1:0] room_need;

	logic valid_s1;
	logic fwd_s1;
	logic [NRES_W-1:0] n_s1;
	pos_flags_t flags_s1;
	pix_t pix_s1;
	logic [COL_W-1:0] col_s1;

	pix_t win_q [5];
	pix_t older_rd;
	pix_t newer_rd;
	pix_t t_eff;
	pix_t m_eff;
	pix_t res [MAX_RESULTS];
	logic [MAX_RESULTS-1:0] res_en;
	out_item_t cand [MAX_RESULTS];

	// effective region size
	assign width_ext = EXT_W'(width_q);
	always_comb begin
		if (width_ext == '0) begin
			width_eff = EXT_W'(1);
		end else if (width_ext > EXT_W'(MAX_ROW_PIXELS)) begin
			width_eff = EXT_W'(MAX_ROW_PIXELS);
		end else begin
			width_eff = width_ext;
		end
	end
	assign col_last = COL_W'(width_eff - EXT_W'(1));
	assign row_last = (height_q == '0) ? '0 : ROW_W'(height_q - HEIGHT_W'(1));

	always_comb begin
		flags0.c_ge1 = (col_q != '0);
		flags0.c_ge2 = ({1'b0, col_q} >= (COL_W + 1)'(2));
		flags0.r_ge1 = (row_q != '0);
		flags0.r_ge2 = (row_q >= ROW_W'(2));
		flags0.last_col = (col_q == col_last);
		flags0.last_row = (row_q == row_last);
		n0 = NRES_W'(flags0.c_ge1 && flags0.r_ge1) + NRES_W'(flags0.c_ge1 && flags0.last_row)
			+ NRES_W'(flags0.last_col && flags0.r_ge1)
			+ NRES_W'(flags0.last_col && flags0.last_row);
	end

	// reserve queue room for the item in flight and the one being offered
	assign room_need = (QCNT_W + 2)'(q_count) + (QCNT_W + 2)'(valid_s1 ? n_s1 : '0)
		+ (QCNT_W + 2)'(n0);
	assign in_ready = (room_need <= (QCNT_W + 2)'(QUEUE_DEPTH));
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_WIDTH: width_q <= cfg_wdata[WIDTH_W-1:0];
				CFG_REGION_HEIGHT: height_q <= cfg_wdata[HEIGHT_W-1:0];
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (flags0.last_col) begin
				col_q <= '0;
				row_q <= flags0.last_row ? '0 : ROW_W'(row_q + ROW_W'(1));
			end else begin
				col_q <= COL_W'(col_q + COL_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			// the item in flight writes this column right now: take its values instead
			fwd_s1 <= valid_s1 && (col_s1 == col_q);
			n_s1 <= n0;
			flags_s1 <= flags0;
			col_s1 <= col_q;
			pix_s1 <= '{red: in_data.in_red, green: in_data.in_green, blue: in_data.in_blue};
		end
	end

	lss_line_buf u_line_buf (
		.clk        (clk),
		.rd_en      (in_accept),
		.rd_addr    (col_q),
		.older_rdata(older_rd),
		.newer_rdata(newer_rd),
		.wr_en      (valid_s1),
		.wr_addr    (col_s1),
		.older_wdata(m_eff),
		.newer_wdata(pix_s1)
	);

	// window holds the previous item's row-above pixel in slot 2 and own pixel in slot 4
	assign m_eff = fwd_s1 ? win_q[4] : newer_rd;
	assign t_eff = fwd_s1 ? win_q[2] : older_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				win_q[i] <= '0;
			end
		end else if (valid_s1) begin
			win_q[0] <= t_eff;
			win_q[1] <= win_q[2];
			win_q[2] <= m_eff;
			win_q[3] <= win_q[4];
			win_q[4] <= pix_s1;
		end
	end

	always_comb begin
		res_en[0] = valid_s1 && flags_s1.c_ge1 && flags_s1.r_ge1;
		res_en[1] = valid_s1 && flags_s1.c_ge1 && flags_s1.last_row;
		res_en[2] = valid_s1 && flags_s1.last_col && flags_s1.r_ge1;
		res_en[3] = valid_s1 && flags_s1.last_col && flags_s1.last_row;

		// previous column, row above
		res[0] = lss_sharpen(win_q[2], flags_s1.r_ge2 ? win_q[0] : win_q[2], win_q[4],
			flags_s1.c_ge2 ? win_q[1] : win_q[2], m_eff);
		// previous column, last row
		res[1] = lss_sharpen(win_q[4], flags_s1.r_ge1 ? win_q[2] : win_q[4], win_q[4],
			flags_s1.c_ge2 ? win_q[3] : win_q[4], pix_s1);
		// last column, row above
		res[2] = lss_sharpen(m_eff, flags_s1.r_ge2 ? t_eff : m_eff, pix_s1,
			flags_s1.c_ge1 ? win_q[2] : m_eff, m_eff);
		// last column, last row
		res[3] = lss_sharpen(pix_s1, flags_s1.r_ge1 ? m_eff : pix_s1, pix_s1,
			flags_s1.c_ge1 ? win_q[4] : pix_s1, pix_s1);

		for (int k = 0; k < MAX_RESULTS; k++) begin
			cand[k].out_red = res[k].red;
			cand[k].out_green = res[k].green;
			cand[k].out_blue = res[k].blue;
			cand[k].run_last = res_en[k] && ((res_en >> (k + 1)) == '0);
			cand[k].frame_end = 1'b0;
		end
		cand[MAX_RESULTS-1].frame_end = 1'b1;
	end

	lss_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cand     (cand),
		.cand_en  (res_en),
		.count    (q_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		(QCNT_W + 2)'(q_count) + (QCNT_W + 2)'(valid_s1 ? n_s1 : '0)
			<= (QCNT_W + 2)'(QUEUE_DEPTH))
		else $error("result queue room reservation broken");

	a_fwd_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && fwd_s1 |-> $past(valid_s1) && (col_s1 == $past(col_s1)))
		else $error("row store forwarding without a colliding write");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && flags_s1.last_col && flags_s1.last_row |-> (col_q == '0) && (row_q == '0))
		else $error("counters did not wrap at frame end");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($countones(res_en) == int'(n_s1)))
		else $error("pushed results differ from reserved count");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.run_last)
		else $error("frame end result not marked as last of its pixel");

endmodule
`default_nettype wire
